// ----- hw/rtl/aes128_ctr_byte_decrypt_defines.svh -----
// Assertion macros shared by the AES-128 counter-mode byte decryptor.
`ifndef AES128_CTR_BYTE_DECRYPT_DEFINES_SVH
`define AES128_CTR_BYTE_DECRYPT_DEFINES_SVH
// Assert that an antecedent implies a consequent on the next clock edge.
`define ACB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Assert that a condition holds at every clock edge outside reset.
`define ACB_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

// ----- hw/rtl/acb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acb_pkg
// Types, constants and AES helper functions for the counter-mode decryptor.
// ----------------------------------------------------------------------------
package acb_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 64;

    typedef enum logic [CfgIdxW-1:0] {
        REG_KEY_LOW    = 2'd0,
        REG_KEY_HIGH   = 2'd1,
        REG_NONCE_LOW  = 2'd2,
        REG_NONCE_HIGH = 2'd3
    } cfg_reg_t;

    typedef logic [127:0] block_t;

    // Per-stage sideband carried alongside the AES state.
    typedef struct packed {
        logic       valid;
        logic [7:0] cipher;
        logic [3:0] sel;
    } side_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        begin
            case (a)
                8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
                8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
                8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
                8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
                8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
                8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
                8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
                8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
                8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
                8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
                8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
                8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
                8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
                8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
                8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
                8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
                8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
                8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
                8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
                8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
                8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
                8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
                8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
                8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
                8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
                8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
                8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
                8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
                8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
                8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
                8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
                8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
                8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
                8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
                8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
                8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
                8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
                8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
                8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
                8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
                8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
                8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
                8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
                8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
                8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
                8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
                8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
                8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
                8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
                8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
                8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
                8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
                8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
                8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
                8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
                8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
                8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
                8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
                8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
                8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
                8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
                8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
                8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
                8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        begin
            return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
        end
    endfunction

    // Byte i of a block sits in bits 8*i+7 : 8*i (row i%4, column i/4).
    function automatic block_t aes_round(input block_t s, input block_t rk,
                                         input logic last);
        block_t t;
        block_t m;
        logic [7:0] a0, a1, a2, a3, all;
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[8*(i+4*c) +: 8] = sbox(s[8*(i + 4*((c+i) % 4)) +: 8]);
            m = t;
            for (int c = 0; c < 4; c++)
            begin
                a0  = t[8*(4*c)   +: 8];
                a1  = t[8*(4*c+1) +: 8];
                a2  = t[8*(4*c+2) +: 8];
                a3  = t[8*(4*c+3) +: 8];
                all = a0 ^ a1 ^ a2 ^ a3;
                m[8*(4*c)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
                m[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
                m[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
                m[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
            end
            return (last ? t : m) ^ rk;
        end
    endfunction

    // Next round key from the previous one and the round constant.
    function automatic block_t key_step(input block_t k, input logic [7:0] rcon);
        block_t n;
        logic [31:0] t;
        begin
            t = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]),
                 sbox(k[111:104]) ^ rcon};
            n[31:0]   = k[31:0]   ^ t;
            n[63:32]  = k[63:32]  ^ n[31:0];
            n[95:64]  = k[95:64]  ^ n[63:32];
            n[127:96] = k[127:96] ^ n[95:64];
            return n;
        end
    endfunction

    function automatic logic [7:0] rcon_of(input logic [3:0] r);
        logic [7:0] v;
        begin
            case (r)
                4'd1:    v = 8'h01;
                4'd2:    v = 8'h02;
                4'd3:    v = 8'h04;
                4'd4:    v = 8'h08;
                4'd5:    v = 8'h10;
                4'd6:    v = 8'h20;
                4'd7:    v = 8'h40;
                4'd8:    v = 8'h80;
                4'd9:    v = 8'h1b;
                4'd10:   v = 8'h36;
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- hw/rtl/acb_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acb_round
// One registered AES round: state and round key advance together by one stage.
// ----------------------------------------------------------------------------
`include "aes128_ctr_byte_decrypt_defines.svh"
module acb_round #(
    parameter logic [3:0] ROUND = 4'd1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  acb_pkg::side_t side_in,
    input  acb_pkg::block_t state_in,
    input  acb_pkg::block_t key_in,
    output acb_pkg::side_t side_out,
    output acb_pkg::block_t state_out,
    output acb_pkg::block_t key_out
);

    acb_pkg::block_t rk;
    acb_pkg::side_t  side_reg;
    acb_pkg::block_t state_reg;
    acb_pkg::block_t key_reg;

    // The round key is derived inline so each stage carries its own copy.
    assign rk = acb_pkg::key_step(key_in, acb_pkg::rcon_of(ROUND));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else
        begin
            side_reg.valid  <= side_in.valid;
            side_reg.cipher <= side_in.cipher;
            side_reg.sel    <= side_in.sel;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= acb_pkg::aes_round(state_in, rk, ROUND == 4'd10);
        key_reg   <= rk;
    end

    assign side_out  = side_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;

    `ACB_ASSERT_NEXT(a_valid_follows, clk, rst_n, side_in.valid, side_reg.valid,
        "round stage dropped a valid item")
    `ACB_ASSERT_NEXT(a_no_ghost, clk, rst_n, !side_in.valid, !side_reg.valid,
        "round stage invented an item")
    `ACB_ASSERT_NEXT(a_sel_carried, clk, rst_n, side_in.valid,
        side_reg.sel == $past(side_in.sel), "byte select lost in round stage")

endmodule

// ----- hw/rtl/aes128_ctr_byte_decrypt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_ctr_byte_decrypt
// AES-128 counter-mode byte decryptor, fully pipelined.
// ----------------------------------------------------------------------------
// A byte is taken on every cycle with start high (busy stays low); its plain
// byte appears with done high after passing all stages: one forms the
// counter low half and carry, one adds the high half and the initial key,
// ten are unrolled rounds, one is the output register. Throughput is one
// byte per cycle; the receiver cannot stall, so results must be taken as
// they come. Write the key and nonce only while no bytes are in flight.
`include "aes128_ctr_byte_decrypt_defines.svh"
module aes128_ctr_byte_decrypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  cipher_byte,
    input  logic [62:0] byte_position,
    output logic        done,
    output logic [7:0]  plain_byte,
    input  logic        cfg_we,
    input  logic [acb_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [acb_pkg::CfgDataW-1:0] cfg_data
);

    logic [63:0] key_low_reg, key_high_reg, nonce_low_reg, nonce_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (acb_pkg::cfg_reg_t'(cfg_index))
                acb_pkg::REG_KEY_LOW:    key_low_reg    <= cfg_data;
                acb_pkg::REG_KEY_HIGH:   key_high_reg   <= cfg_data;
                acb_pkg::REG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                acb_pkg::REG_NONCE_HIGH: nonce_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 0: counter low half and carry.
    acb_pkg::side_t s0_reg;
    logic [63:0]    lo_reg;
    logic           carry_reg;
    logic [64:0]    lo_sum;

    assign lo_sum = {1'b0, nonce_low_reg} + {6'd0, byte_position[62:4]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_reg <= '0;
        else
        begin
            s0_reg.valid  <= start && !busy;
            s0_reg.cipher <= cipher_byte;
            s0_reg.sel    <= byte_position[3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_sum[63:0];
        carry_reg <= lo_sum[64];
    end

    // Stage 1: high half, then the initial key addition.
    acb_pkg::side_t  s1_reg;
    acb_pkg::block_t st1_reg;
    acb_pkg::block_t key0;

    assign key0 = {key_high_reg, key_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_reg <= '0;
        else
            s1_reg <= s0_reg;
    end

    always_ff @(posedge clk)
    begin
        st1_reg <= {nonce_high_reg + {63'd0, carry_reg}, lo_reg} ^ key0;
    end

    acb_pkg::side_t  side_w  [acb_pkg::NumRounds+1];
    acb_pkg::block_t state_w [acb_pkg::NumRounds+1];
    acb_pkg::block_t key_w   [acb_pkg::NumRounds+1];

    assign side_w[0]  = s1_reg;
    assign state_w[0] = st1_reg;
    assign key_w[0]   = key0;

    for (genvar r = 0; r < acb_pkg::NumRounds; r++)
    begin : g_round
        acb_round #(.ROUND(4'(r + 1))) u_round (
            .clk      (clk),
            .rst_n    (rst_n),
            .side_in  (side_w[r]),
            .state_in (state_w[r]),
            .key_in   (key_w[r]),
            .side_out (side_w[r+1]),
            .state_out(state_w[r+1]),
            .key_out  (key_w[r+1])
        );
    end

    // Output stage: pick the keystream byte and apply it.
    acb_pkg::side_t  fin;
    acb_pkg::block_t ks;
    logic            done_reg;
    logic [7:0]      plain_reg;

    assign fin = side_w[acb_pkg::NumRounds];
    assign ks  = state_w[acb_pkg::NumRounds];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= fin.valid;
    end

    always_ff @(posedge clk)
    begin
        plain_reg <= fin.cipher ^ ks[{fin.sel, 3'b000} +: 8];
    end

    assign done       = done_reg;
    assign plain_byte = plain_reg;

    `ACB_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy, "decryptor reported busy")
    `ACB_ASSERT_NEXT(a_out_follows, clk, rst_n, fin.valid, done,
        "final stage item did not reach the output")
    `ACB_ASSERT_NEXT(a_stage1, clk, rst_n, s0_reg.valid, s1_reg.valid,
        "counter stage dropped a transfer")

endmodule

// ----- sim/aes128_ctr_byte_decrypt_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_ctr_byte_decrypt_test
// Self-checking bench for the counter-mode byte decryptor. Bytes are offered
// with random gaps (bar the last phase) under several key and nonce settings,
// and each plain byte is checked against an independent AES-128 CTR predictor.
// ----------------------------------------------------------------------------
module aes128_ctr_byte_decrypt_test;

    typedef struct {
        logic [7:0]  cipher;
        logic [62:0] pos;
    } byte_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  cipher_byte = '0;
    logic [62:0] byte_position = '0;
    logic        done;
    logic [7:0]  plain_byte;
    logic        cfg_we = 1'b0;
    logic [acb_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [acb_pkg::CfgDataW-1:0] cfg_data = '0;

    logic [63:0] key_lo_m, key_hi_m, nonce_lo_m, nonce_hi_m;
    logic [7:0]  sub_tab [256];
    byte_item_t  pending_bytes [$];
    logic [7:0]  expected_plain [$];
    bit          feed_on = 1'b0;
    bit          gaps_on = 1'b1;
    int          gap_left = 0;
    int          mismatches = 0;
    int          transfers = 0;
    int          cycles = 0;
    int          settings_used = 0;

    aes128_ctr_byte_decrypt u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cipher_byte(cipher_byte), .byte_position(byte_position),
        .done(done), .plain_byte(plain_byte),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] gf_dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = gf_dbl(a);
        end
        return p;
    endfunction

    // S-box built from the field inverse (a^254) and the affine map.
    function automatic logic [7:0] sub_calc(input logic [7:0] a);
        logic [7:0] inv, b;
        inv = 8'h01;
        for (int i = 0; i < 254; i++)
            inv = gf_mul(inv, a);
        b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
              ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        return b;
    endfunction

    function automatic logic [7:0] decrypt_byte(input logic [7:0] c, input logic [62:0] pos);
        logic [127:0] ctr, key;
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   rk [176];
        logic [7:0]   w [4];
        logic [7:0]   tmp, rc, a0, a1, a2, a3, all;
        ctr = {nonce_hi_m, nonce_lo_m} + 128'(pos >> 4);
        key = {key_hi_m, key_lo_m};
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = key[8*i +: 8];
            s[i]  = ctr[8*i +: 8] ^ rk[i];
        end
        rc = 8'h01;
        for (int i = 16; i < 176; i += 4)
        begin
            for (int j = 0; j < 4; j++)
                w[j] = rk[i-4+j];
            if (i % 16 == 0)
            begin
                tmp  = w[0];
                w[0] = sub_tab[w[1]] ^ rc;
                w[1] = sub_tab[w[2]];
                w[2] = sub_tab[w[3]];
                w[3] = sub_tab[tmp];
                rc   = gf_dbl(rc);
            end
            for (int j = 0; j < 4; j++)
                rk[i+j] = rk[i-16+j] ^ w[j];
        end
        for (int r = 1; r <= 10; r++)
        begin
            for (int col = 0; col < 4; col++)
                for (int row = 0; row < 4; row++)
                    t[row+4*col] = sub_tab[s[row + 4*((col+row) % 4)]];
            if (r != 10)
            begin
                for (int col = 0; col < 4; col++)
                begin
                    a0 = t[4*col]; a1 = t[4*col+1]; a2 = t[4*col+2]; a3 = t[4*col+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    t[4*col]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
                    t[4*col+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
                    t[4*col+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
                    t[4*col+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ rk[16*r+i];
        end
        return c ^ s[pos[3:0]];
    endfunction

    // Driver: holds an offered byte until its transfer, then moves on.
    always @(posedge clk)
    begin
        byte_item_t it;
        bit go;
        go = 1'b0;
        if (start && busy)
            go = 1'b1;
        else if (gap_left > 0)
            gap_left--;
        else if (feed_on && pending_bytes.size() > 0)
        begin
            it = pending_bytes.pop_front();
            cipher_byte   <= it.cipher;
            byte_position <= it.pos;
            go = 1'b1;
            if (gaps_on && $urandom_range(0, 7) == 0)
                gap_left = $urandom_range(1, 15);
        end
        start <= go;
    end

    // Monitor: predicts on each input transfer and checks each result.
    always @(posedge clk)
    begin
        logic [7:0] exp_b;
        cycles++;
        if (rst_n && start && !busy)
        begin
            expected_plain.push_back(decrypt_byte(cipher_byte, byte_position));
            transfers++;
        end
        if (rst_n && done)
        begin
            if (expected_plain.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: plain_byte=%02h", plain_byte);
            end
            else
            begin
                exp_b = expected_plain.pop_front();
                if (plain_byte !== exp_b)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("plain_byte mismatch: expected %02h, got %02h",
                                 exp_b, plain_byte);
                end
            end
        end
        if (cycles > 200000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_bytes.size() != 0 || start || expected_plain.size() != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic program_regs(input logic [63:0] k0, input logic [63:0] k1,
                                input logic [63:0] n0, input logic [63:0] n1);
        logic [63:0] v [4];
        v = '{k0, k1, n0, n1};
        for (int i = 0; i < 4; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= acb_pkg::cfg_reg_t'(i);
            cfg_data  <= v[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        key_lo_m = k0; key_hi_m = k1; nonce_lo_m = n0; nonce_hi_m = n1;
        settings_used++;
    endtask

    task automatic add_byte(input logic [7:0] c, input logic [62:0] p);
        byte_item_t it;
        it.cipher = c;
        it.pos    = p;
        pending_bytes.push_back(it);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly contiguous content streams from a random base, some scattered bytes.
    task automatic add_random(input int count);
        logic [62:0] base;
        int run;
        while (count > 0)
        begin
            case ($urandom_range(0, 3))
                0: add_byte(8'($urandom_range(0, 255)), 63'(rand64()));
                1: add_byte(8'($urandom_range(0, 255)), 63'($urandom_range(0, 300)));
                default:
                begin
                    base = $urandom_range(0, 1) ? 63'(rand64()) : 63'($urandom_range(0, 4096));
                    run  = $urandom_range(1, 40);
                    for (int i = 0; i < run; i++)
                        add_byte(8'($urandom_range(0, 255)), base + 63'(i));
                    count -= run - 1;
                end
            endcase
            count--;
        end
    endtask

    initial
    begin
        logic [63:0] ones;
        ones = '1;
        for (int i = 0; i < 256; i++)
            sub_tab[i] = sub_calc(8'(i));
        key_lo_m = '0; key_hi_m = '0; nonce_lo_m = '0; nonce_hi_m = '0;
        repeat (7) @(posedge clk);
        rst_n = 1'b1;

        // Reset values: key and nonce all zero.
        add_byte(8'h00, 63'd0);
        add_byte(8'hff, 63'd15);
        add_byte(8'h5a, 63'd16);
        add_byte(8'ha5, '1);
        add_byte(8'h00, 63'h4000_0000_0000_0000);
        add_byte(8'hff, 63'h3fff_ffff_ffff_fff0);
        feed_on = 1'b1;
        wait_drained();

        // Nonce at the top of the counter space: the block index wraps it.
        program_regs(ones, ones, ones, ones);
        for (int i = 0; i < 8; i++)
            add_byte(i[0] ? 8'hff : 8'h00, 63'(i * 9));
        add_byte(8'h3c, '1);
        wait_drained();

        // Carry out of the low nonce half into the high half.
        program_regs(64'h0f0e0d0c0b0a0908, 64'h0706050403020100, ones - 64'd1, 64'd0);
        for (int i = 0; i < 6; i++)
            add_byte(8'($urandom_range(0, 255)), 63'(i * 16 + 15));
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 5)
                program_regs('0, '0, ones, '0);
            else
                program_regs(rand64(), rand64(), rand64(), rand64());
            gaps_on = (ph != 5);
            add_random(250);
            wait_drained();
        end

        $display("Covered %0d byte transfers under %0d key/nonce settings, including",
                 transfers, settings_used);
        $display("counter wrap, carry into the high nonce half and extreme offsets.");
        if (mismatches == 0 && expected_plain.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/acb_pkg.sv
hw/rtl/acb_round.sv
hw/rtl/aes128_ctr_byte_decrypt.sv
sim/aes128_ctr_byte_decrypt_test.sv
